@@ sv/spq_pkg.sv @@
package spq_pkg;

  localparam int unsigned OPCODE_BITS = 2;
  localparam int unsigned KEY_BITS    = 32;
  localparam int unsigned STATUS_BITS = 2;
  localparam int unsigned COUNT_BITS  = 5;

  typedef enum logic [OPCODE_BITS-1:0] {
    OP_INSERT = 2'd0,
    OP_POP    = 2'd1,
    OP_REMOVE = 2'd2
  } spq_op_e;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_MISSING = 2'd3
  } spq_status_e;

  typedef struct packed {
    logic ins;
    logic pop;
    logic rem;
  } spq_cmd_t;

endpackage

@@ sv/spq_if.sv @@
interface spq_in_if
  import spq_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic [OPCODE_BITS-1:0] opcode;
  logic [KEY_BITS-1:0]    key;

  modport source (output valid, output opcode, output key, input ready);
  modport sink   (input valid, input opcode, input key, output ready);
endinterface

interface spq_out_if
  import spq_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic [KEY_BITS-1:0]    out_key;
  logic [STATUS_BITS-1:0] status;
  logic [COUNT_BITS-1:0]  count;

  modport source (output valid, output out_key, output status, output count, input ready);
  modport sink   (input valid, input out_key, input status, input count, output ready);
endinterface

@@ sv/spq_cell.sv @@
module spq_cell
  import spq_pkg::*;
#(
  parameter int unsigned KEY_WIDTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  spq_cmd_t             cmd_i,
  input  logic [KEY_WIDTH-1:0] key_i,
  input  logic                 prev_valid_i,
  input  logic [KEY_WIDTH-1:0] prev_key_i,
  input  logic                 prev_gt_i,
  input  logic                 next_valid_i,
  input  logic [KEY_WIDTH-1:0] next_key_i,
  output logic                 valid_o,
  output logic [KEY_WIDTH-1:0] key_o,
  output logic                 gt_o,
  output logic                 eq_o
);

  logic                 valid_q, valid_d;
  logic [KEY_WIDTH-1:0] key_q, key_d;
  logic                 le;

  assign gt_o    = !valid_q || (key_i > key_q);
  assign eq_o    = valid_q && (key_q == key_i);
  assign le      = !valid_q || (key_q <= key_i);
  assign valid_o = valid_q;
  assign key_o   = key_q;

  // New keys enter behind equal keys; removal closes the gap from the first match on.
  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    if (cmd_i.ins) begin
      if (prev_gt_i) begin
        valid_d = prev_valid_i;
        key_d   = prev_key_i;
      end else if (gt_o) begin
        valid_d = 1'b1;
        key_d   = key_i;
      end
    end else if (cmd_i.pop || (cmd_i.rem && le)) begin
      valid_d = next_valid_i;
      key_d   = next_key_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

endmodule

@@ sv/sorted_priority_queue.sv @@
// Latency: a result is presented in the cycle after its operation is accepted.
// Throughput: one operation per cycle unless a result waits on out_o.ready; every
// cell of the sorted row updates in parallel, and the output register accepts a
// new beat while the previous one is taken.
// Reset: the held count, the cell valid bits and the output valid are cleared.
module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int unsigned CAPACITY  = 16,
  parameter int unsigned KEY_WIDTH = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  spq_in_if.sink    in_i,
  spq_out_if.source out_o
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic [CAPACITY-1:0]  cell_valid;
  logic [KEY_WIDTH-1:0] cell_key [CAPACITY];
  logic [CAPACITY-1:0]  cell_gt;
  logic [CAPACITY-1:0]  cell_eq;

  spq_cmd_t             cmd;
  logic [KEY_WIDTH-1:0] key_red;
  logic [63:0]          key_in_ext;
  logic [63:0]          key_red_ext;
  logic [63:0]          head_ext;
  logic [31:0]          count_ext;
  logic                 accept;
  logic                 full;
  logic                 empty;
  logic                 found;

  logic [CW-1:0]          count_q, count_d;
  logic                   out_valid_q, out_valid_d;
  logic [KEY_BITS-1:0]    out_key_q, out_key_d;
  logic [STATUS_BITS-1:0] status_q, status_d;
  logic [COUNT_BITS-1:0]  out_count_q, out_count_d;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign full       = (count_q == CW'(CAPACITY));
  assign empty      = (count_q == '0);
  assign found      = |cell_eq;

  always_comb begin
    key_in_ext                   = '0;
    key_in_ext[KEY_BITS-1:0]     = in_i.key;
    key_red                      = key_in_ext[KEY_WIDTH-1:0];
    key_red_ext                  = '0;
    key_red_ext[KEY_WIDTH-1:0]   = key_red;
    head_ext                     = '0;
    head_ext[KEY_WIDTH-1:0]      = cell_key[0];
  end

  always_comb begin
    cmd.ins = 1'b0;
    cmd.pop = 1'b0;
    cmd.rem = 1'b0;
    if (accept) begin
      unique case (in_i.opcode)
        OP_INSERT: cmd.ins = !full;
        OP_POP:    cmd.pop = !empty;
        OP_REMOVE: cmd.rem = found;
        default:   ;
      endcase
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd.ins) begin
      count_d = count_q + CW'(1);
    end else if (cmd.pop || cmd.rem) begin
      count_d = count_q - CW'(1);
    end
    count_ext           = '0;
    count_ext[CW-1:0]   = count_d;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_key_d   = out_key_q;
    status_d    = status_q;
    out_count_d = out_count_q;
    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (accept) begin
      out_valid_d = 1'b1;
      out_key_d   = key_red_ext[KEY_BITS-1:0];
      status_d    = ST_OK;
      out_count_d = count_ext[COUNT_BITS-1:0];
      unique case (in_i.opcode)
        OP_INSERT: begin
          if (full) begin
            status_d = ST_FULL;
          end
        end
        OP_POP: begin
          if (empty) begin
            status_d  = ST_EMPTY;
            out_key_d = '0;
          end else begin
            out_key_d = head_ext[KEY_BITS-1:0];
          end
        end
        OP_REMOVE: begin
          if (!found) begin
            status_d = ST_MISSING;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_key_q   <= out_key_d;
    status_q    <= status_d;
    out_count_q <= out_count_d;
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.out_key = out_key_q;
  assign out_o.status  = status_q;
  assign out_o.count   = out_count_q;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                 prev_valid;
    logic [KEY_WIDTH-1:0] prev_key;
    logic                 prev_gt;
    logic                 next_valid;
    logic [KEY_WIDTH-1:0] next_key;

    if (i == 0) begin : g_first
      assign prev_valid = 1'b0;
      assign prev_key   = '0;
      assign prev_gt    = 1'b0;
    end else begin : g_mid
      assign prev_valid = cell_valid[i-1];
      assign prev_key   = cell_key[i-1];
      assign prev_gt    = cell_gt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign next_valid = 1'b0;
      assign next_key   = '0;
    end else begin : g_inner
      assign next_valid = cell_valid[i+1];
      assign next_key   = cell_key[i+1];
    end

    spq_cell #(
      .KEY_WIDTH (KEY_WIDTH)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .key_i        (key_red),
      .prev_valid_i (prev_valid),
      .prev_key_i   (prev_key),
      .prev_gt_i    (prev_gt),
      .next_valid_i (next_valid),
      .next_key_i   (next_key),
      .valid_o      (cell_valid[i]),
      .key_o        (cell_key[i]),
      .gt_o         (cell_gt[i]),
      .eq_o         (cell_eq[i])
    );
  end

endmodule

@@ tb/sorted_priority_queue_tb.sv @@
`timescale 1ns / 1ps

module sorted_priority_queue_tb;
  import spq_pkg::*;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned QUIET_LIMIT = 5000;
  localparam logic [OPCODE_BITS-1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [OPCODE_BITS-1:0] opcode;
    logic [KEY_BITS-1:0]    key;
    int unsigned            gap;
    bit                     drain;
  } queue_op_t;

  typedef struct {
    logic [KEY_BITS-1:0]   key;
    spq_status_e           status;
    logic [COUNT_BITS-1:0] count;
  } queue_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b1;

  spq_in_if  in_bus ();
  spq_out_if out_bus ();

  sorted_priority_queue #(
    .CAPACITY (QUEUE_DEPTH),
    .KEY_WIDTH(KEY_BITS)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  queue_op_t           pending_ops[$];
  queue_result_t       expected_results[$];
  logic [KEY_BITS-1:0] held_keys[QUEUE_DEPTH];
  int                  held_count = 0;
  logic [KEY_BITS-1:0] key_pool[8];
  int unsigned         gap_count;
  int unsigned         stall_left;
  int unsigned         results_seen;
  int unsigned         quiet_cycles = 0;
  int unsigned         mismatches = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic queue_result_t queue_update(input logic [OPCODE_BITS-1:0] op,
                                                 input logic [KEY_BITS-1:0] key);
    queue_result_t res;
    int pos;
    int i;
    res.key    = key;
    res.status = ST_OK;
    case (op)
      OP_INSERT: begin
        if (held_count >= QUEUE_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          pos = 0;
          while (pos < held_count && key <= held_keys[pos]) pos++;
          for (i = held_count; i > pos; i--) held_keys[i] = held_keys[i-1];
          held_keys[pos] = key;
          held_count++;
        end
      end
      OP_POP: begin
        if (held_count == 0) begin
          res.key    = '0;
          res.status = ST_EMPTY;
        end else begin
          res.key = held_keys[0];
          for (i = 1; i < held_count; i++) held_keys[i-1] = held_keys[i];
          held_count--;
        end
      end
      OP_REMOVE: begin
        pos = 0;
        while (pos < held_count && held_keys[pos] != key) pos++;
        if (pos == held_count) begin
          res.status = ST_MISSING;
        end else begin
          for (i = pos + 1; i < held_count; i++) held_keys[i-1] = held_keys[i];
          held_count--;
        end
      end
      default: ;
    endcase
    res.count = COUNT_BITS'(held_count);
    return res;
  endfunction

  function automatic logic [KEY_BITS-1:0] rand_key();
    case ($urandom_range(0, 7))
      0, 1, 2, 3: return key_pool[$urandom_range(0, 7)];
      4, 5:       return $urandom;
      6:          return $urandom_range(0, 1) ? '1 : '0;
      default:    return KEY_BITS'(1) << $urandom_range(0, KEY_BITS - 1);
    endcase
  endfunction

  function automatic logic [OPCODE_BITS-1:0] pick_op(input int mode);
    int r;
    int ins_pct;
    int pop_pct;
    r = $urandom_range(0, 99);
    case (mode)
      0: begin
        ins_pct = 70;
        pop_pct = 15;
      end
      1: begin
        ins_pct = 25;
        pop_pct = 55;
      end
      2: begin
        ins_pct = 40;
        pop_pct = 10;
      end
      default: begin
        ins_pct = 40;
        pop_pct = 30;
      end
    endcase
    if (r < 3) return OP_UNUSED;
    if (r < 3 + ins_pct) return OP_INSERT;
    if (r < 3 + ins_pct + pop_pct) return OP_POP;
    return OP_REMOVE;
  endfunction

  function automatic int unsigned ready_delay(input int unsigned seen);
    if (seen == 300) return 400;
    if ((seen / 80) % 3 == 0) return 0;
    return $urandom_range(0, 13);
  endfunction

  task automatic add_op(input logic [OPCODE_BITS-1:0] op, input logic [KEY_BITS-1:0] key,
                        input int unsigned gap, input bit drain);
    queue_op_t item;
    item.opcode = op;
    item.key    = key;
    item.gap    = gap;
    item.drain  = drain;
    pending_ops.push_back(item);
  endtask

  always @(posedge clk or negedge rst_n) begin : op_driver
    queue_op_t next_op;
    if (!rst_n) begin
      in_bus.valid  <= 1'b0;
      in_bus.opcode <= '0;
      in_bus.key    <= '0;
      gap_count     <= 0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        expected_results.push_back(queue_update(in_bus.opcode, in_bus.key));
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (pending_ops.size() == 0) begin
          in_bus.valid <= 1'b0;
        end else if (gap_count < pending_ops[0].gap ||
                     (pending_ops[0].drain && expected_results.size() != 0)) begin
          in_bus.valid <= 1'b0;
          if (gap_count < pending_ops[0].gap) gap_count <= gap_count + 1;
        end else begin
          next_op = pending_ops.pop_front();
          in_bus.valid  <= 1'b1;
          in_bus.opcode <= next_op.opcode;
          in_bus.key    <= next_op.key;
          gap_count     <= 0;
        end
      end
    end
  end

  always @(posedge clk or negedge rst_n) begin : result_check
    queue_result_t want;
    int unsigned wait_next;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      stall_left    <= 0;
      results_seen  <= 0;
    end else begin
      wait_next = stall_left;
      if (out_bus.valid && out_bus.ready) begin
        if (expected_results.size() == 0) begin
          $error("result beat with no operation outstanding: out_key %h status %0d count %0d",
                 out_bus.out_key, out_bus.status, out_bus.count);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (out_bus.out_key !== want.key) begin
            $error("out_key mismatch: expected %h, got %h", want.key, out_bus.out_key);
            mismatches++;
          end
          if (out_bus.status !== want.status) begin
            $error("status mismatch: expected %0d, got %0d", want.status, out_bus.status);
            mismatches++;
          end
          if (out_bus.count !== want.count) begin
            $error("count mismatch: expected %0d, got %0d", want.count, out_bus.count);
            mismatches++;
          end
        end
        wait_next = ready_delay(results_seen);
        results_seen <= results_seen + 1;
      end else if (wait_next > 0) begin
        wait_next--;
      end
      stall_left    <= wait_next;
      out_bus.ready <= (wait_next == 0);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int mode;
    bit no_gaps;
    int k;
    int blk;
    int j;
    #0 rst_n = 1'b0;
    for (k = 0; k < 8; k++) key_pool[k] = $urandom;
    key_pool[0] = '0;
    key_pool[1] = '1;

    add_op(OP_POP, $urandom, $urandom_range(0, 13), 1'b0);
    add_op(OP_REMOVE, 32'd7, $urandom_range(0, 13), 1'b0);
    add_op(OP_UNUSED, 32'hA5A5_A5A5, $urandom_range(0, 13), 1'b0);
    add_op(OP_INSERT, '0, $urandom_range(0, 13), 1'b0);
    add_op(OP_INSERT, '1, $urandom_range(0, 13), 1'b0);
    add_op(OP_INSERT, 32'd5, $urandom_range(0, 13), 1'b0);
    add_op(OP_INSERT, 32'd5, $urandom_range(0, 13), 1'b0);
    add_op(OP_REMOVE, 32'd5, $urandom_range(0, 13), 1'b0);
    add_op(OP_REMOVE, 32'd6, $urandom_range(0, 13), 1'b0);
    add_op(OP_POP, '1, $urandom_range(0, 13), 1'b0);
    for (k = 0; k < 14; k++) add_op(OP_INSERT, rand_key(), $urandom_range(0, 13), 1'b0);
    add_op(OP_INSERT, '1, $urandom_range(0, 13), 1'b0);
    add_op(OP_INSERT, '0, $urandom_range(0, 13), 1'b0);

    for (blk = 0; blk < 17; blk++) begin
      mode    = $urandom_range(0, 3);
      no_gaps = ($urandom_range(0, 3) == 0);
      for (j = 0; j < 50; j++) begin
        add_op(pick_op(mode), rand_key(), no_gaps ? 0 : $urandom_range(0, 13),
               j == 0 && (blk == 6 || blk == 12));
      end
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_ops.size() != 0 || in_bus.valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ sorted_priority_queue.f @@
sv/spq_pkg.sv
sv/spq_if.sv
sv/spq_cell.sv
sv/sorted_priority_queue.sv
tb/sorted_priority_queue_tb.sv
